// ===== rtl/assert_macros.svh =====
// assert_macros.svh: assertion macros used by the checker file ssr_checker.sv
// depends on nothing; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/ssr_pkg.sv =====
// ssr_pkg: types, constants and glyph functions of the seven-segment renderer
// used by all modules of the renderer; depends on nothing
`default_nettype none

package ssr_pkg;

    // opcodes as they arrive on the request channel
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_EMIT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // cell codes on the result channel
    localparam logic [1:0] CELL_BLANK = 2'd0;
    localparam logic [1:0] CELL_DASH  = 2'd1;
    localparam logic [1:0] CELL_BAR   = 2'd2;

    localparam logic [3:0] SCALE_RESET = 4'd2;
    localparam int QUEUE_DEPTH = 4;

    // command handed from the front to the back
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_EMIT,
        CMD_CLEAR
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] digit;
    } t_cmd_req;

    // segment bits: 0 top, 1 upper-left, 2 upper-right, 3 middle,
    // 4 lower-left, 5 lower-right, 6 bottom
    function automatic logic [6:0] seg_of(input logic [3:0] code);
        logic [6:0] segs;
        begin
            case (code)
                4'd0: segs = 7'h77;
                4'd1: segs = 7'h24;
                4'd2: segs = 7'h5D;
                4'd3: segs = 7'h6D;
                4'd4: segs = 7'h2E;
                4'd5: segs = 7'h6B;
                4'd6: segs = 7'h7B;
                4'd7: segs = 7'h25;
                4'd8: segs = 7'h7F;
                4'd9: segs = 7'h6F;
                default: segs = 7'h00;
            endcase
            return segs;
        end
    endfunction

    // cell of a glyph at row r, column c for segment length s
    function automatic logic [1:0] cell_of(input logic [6:0] segs, input logic [5:0] r,
                                           input logic [4:0] c, input logic [3:0] s);
        logic [6:0] r7;
        logic [6:0] s7;
        logic [2:0] band;
        logic [1:0] part;
        logic [1:0] res;
        begin
            r7 = {1'b0, r};
            s7 = {3'b000, s};
            if (r7 == 7'd0) band = 3'd0;
            else if (r7 <= s7) band = 3'd1;
            else if (r7 == s7 + 7'd1) band = 3'd2;
            else if (r7 <= {s7[5:0], 1'b0} + 7'd1) band = 3'd3;
            else band = 3'd4;
            if (c == 5'd0) part = 2'd0;
            else if (c <= {1'b0, s}) part = 2'd1;
            else part = 2'd2;
            res = CELL_BLANK;
            case (band)
                3'd0: if (part == 2'd1 && segs[0]) res = CELL_DASH;
                3'd2: if (part == 2'd1 && segs[3]) res = CELL_DASH;
                3'd4: if (part == 2'd1 && segs[6]) res = CELL_DASH;
                3'd1: begin
                    if (part == 2'd0 && segs[1]) res = CELL_BAR;
                    if (part == 2'd2 && segs[2]) res = CELL_BAR;
                end
                3'd3: begin
                    if (part == 2'd0 && segs[4]) res = CELL_BAR;
                    if (part == 2'd2 && segs[5]) res = CELL_BAR;
                end
                default: res = CELL_BLANK;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ssr_front.sv =====
// ssr_front: request decode; turns opcodes into commands for the queue
// depends on ssr_pkg
`default_nettype none

module ssr_front (
    input  wire logic             i_valid,
    input  wire logic [1:0]       i_opcode,
    input  wire logic [3:0]       i_digit,
    input  wire logic             i_q_full,
    output ssr_pkg::t_cmd_req     o_req,
    output logic                  o_push,
    output logic                  o_stall
);
    import ssr_pkg::*;

    logic is_legal;

    // hold the request while the queue has no room
    assign o_stall = i_q_full;

    // classify; the unused opcode is taken and dropped
    always_comb begin
        is_legal    = 1'b1;
        o_req.digit = i_digit;
        case (i_opcode)
            OP_LOAD:  o_req.cmd = CMD_LOAD;
            OP_EMIT:  o_req.cmd = CMD_EMIT;
            OP_CLEAR: o_req.cmd = CMD_CLEAR;
            default: begin
                o_req.cmd = CMD_EMIT;
                is_legal  = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && !i_q_full && is_legal;

endmodule

`default_nettype wire

// ===== rtl/ssr_queue.sv =====
// ssr_queue: short command queue between front and back
// depends on ssr_pkg
`default_nettype none

module ssr_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ssr_pkg::t_cmd_req i_req,
    output logic                  o_full,
    output logic                  o_valid,
    output ssr_pkg::t_cmd_req     o_req,
    input  wire logic             i_pop
);
    import ssr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd_req           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) n_wr_ptr = r_wr_ptr + PTR_W'(1);
        if (do_pop) n_rd_ptr = r_rd_ptr + PTR_W'(1);
        if (i_push && !do_pop) n_count = r_count + CNT_W'(1);
        else if (!i_push && do_pop) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_req;
    end

endmodule

`default_nettype wire

// ===== rtl/ssr_back.sv =====
// ssr_back: digit store, raster position counters and cell output stages
// depends on ssr_pkg
`default_nettype none

module ssr_back #(
    parameter int MAX_DIGITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_scale_we,
    input  wire logic [3:0]       i_scale_wdata,
    input  wire logic             i_q_valid,
    input  wire ssr_pkg::t_cmd_req i_q_req,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [1:0]            o_glyph,
    output logic                  o_end_of_row,
    output logic                  o_end_of_frame
);
    import ssr_pkg::*;

    localparam int PW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW  = $clog2(MAX_DIGITS + 1);
    localparam int CW1 = CW + 1;

    // digit store, undefined until written
    logic [3:0]     r_store [MAX_DIGITS];

    logic [3:0]     r_scale;
    logic [CW-1:0]  r_count, n_count;
    logic [5:0]     r_row, n_row;
    logic [PW-1:0]  r_pos, n_pos;
    logic [4:0]     r_col, n_col;

    // stage 1: position resolved, store read in flight
    logic           r_s1_valid, n_s1_valid;
    logic [5:0]     r_s1_row;
    logic [4:0]     r_s1_col;
    logic           r_s1_blank, r_s1_eor, r_s1_eof;
    logic [3:0]     r_rd_code;

    // stage 2: output register
    logic           r_out_valid, n_out_valid;
    logic [1:0]     r_glyph;
    logic           r_eor, r_eof;

    logic           out_free, s1_adv, s1_ready, s1_load, do_load;
    logic [5:0]     last_row, row_w;
    logic [4:0]     last_col, sep_col, col_w;
    logic [PW-1:0]  pos_w;
    logic [CW1-1:0] pos_p1, pos_w_p1, cnt_x;
    logic           wrap, eor, eof;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign s1_ready = !r_s1_valid || out_free;
    assign o_q_pop  = i_q_valid && (i_q_req.cmd != CMD_EMIT || s1_ready);

    // raster geometry for the current scale
    assign last_row = {1'b0, r_scale, 1'b0} + 6'd2;
    assign last_col = {1'b0, r_scale} + 5'd1;
    assign sep_col  = {1'b0, r_scale} + 5'd2;
    assign cnt_x    = CW1'(r_count);
    assign pos_p1   = CW1'(r_pos) + CW1'(1);

    // restart at the first cell when the position is out of range
    assign wrap = (r_row > last_row) || (CW1'(r_pos) >= cnt_x) || (r_col > sep_col)
                  || (r_col == sep_col && pos_p1 >= cnt_x);
    assign row_w    = wrap ? 6'd0 : r_row;
    assign pos_w    = wrap ? '0 : r_pos;
    assign col_w    = wrap ? 5'd0 : r_col;
    assign pos_w_p1 = CW1'(pos_w) + CW1'(1);
    assign eor      = (pos_w_p1 == cnt_x) && (col_w == last_col);
    assign eof      = eor && (row_w == last_row);

    assign s1_load = o_q_pop && i_q_req.cmd == CMD_EMIT && r_count != '0;
    assign do_load = o_q_pop && i_q_req.cmd == CMD_LOAD && cnt_x < CW1'(MAX_DIGITS);

    // command execution and position advance
    always_comb begin
        n_count    = r_count;
        n_row      = r_row;
        n_pos      = r_pos;
        n_col      = r_col;
        n_s1_valid = s1_adv ? 1'b0 : r_s1_valid;
        if (o_q_pop) begin
            case (i_q_req.cmd)
                CMD_LOAD: begin
                    if (do_load) n_count = r_count + CW'(1);
                end
                CMD_CLEAR: begin
                    n_count = '0;
                    n_row   = 6'd0;
                    n_pos   = '0;
                    n_col   = 5'd0;
                end
                CMD_EMIT: begin
                    if (s1_load) begin
                        n_s1_valid = 1'b1;
                        if (eor) begin
                            n_pos = '0;
                            n_col = 5'd0;
                            n_row = eof ? 6'd0 : row_w + 6'd1;
                        end else if (col_w >= sep_col) begin
                            n_col = 5'd0;
                            n_pos = pos_w + PW'(1);
                            n_row = row_w;
                        end else begin
                            n_col = col_w + 5'd1;
                            n_pos = pos_w;
                            n_row = row_w;
                        end
                    end
                end
                default: n_count = r_count;
            endcase
        end
    end

    // output register takes the stage 1 cell
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (s1_adv) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_RESET;
            r_count     <= '0;
            r_row       <= 6'd0;
            r_pos       <= '0;
            r_col       <= 5'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_scale_we) r_scale <= i_scale_wdata;
            r_count     <= n_count;
            r_row       <= n_row;
            r_pos       <= n_pos;
            r_col       <= n_col;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (do_load) r_store[r_count[PW-1:0]] <= i_q_req.digit;
        if (s1_load) r_rd_code <= r_store[pos_w];
    end

    // stage 1 and output payload
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_row   <= row_w;
            r_s1_col   <= col_w;
            r_s1_blank <= (col_w > last_col);
            r_s1_eor   <= eor;
            r_s1_eof   <= eof;
        end
        if (s1_adv) begin
            r_glyph <= r_s1_blank ? CELL_BLANK
                       : cell_of(seg_of(r_rd_code), r_s1_row, r_s1_col, r_scale);
            r_eor   <= r_s1_eor;
            r_eof   <= r_s1_eof;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_glyph        = r_glyph;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

endmodule

`default_nettype wire

// ===== rtl/scaled_seven_segment_renderer_unit.sv =====
// Scaled seven-segment renderer: takes one request per clock while the queue
// has room (load digit, emit next cell, clear) and sustains one cell per clock
// on the result channel unless it stalls. The front decodes requests into a
// four-entry queue; the back runs one queued command per clock unless a stalled
// result side holds an emit. An emit's cell goes from the queue to stage 1,
// where the back takes it from the queue and reads the store, then to the output
// register. A full queue stalls the request side; a stalled result side stops
// only emits in the back. The digit store holds MAX_DIGITS entries and needs no
// clearing after reset. Depends on ssr_pkg, ssr_front, ssr_queue and ssr_back.
`default_nettype none

module scaled_seven_segment_renderer_unit #(
    parameter int MAX_DIGITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_scale_we,
    input  wire logic [3:0]  i_scale_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [3:0]  i_digit,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_glyph,
    output logic             o_end_of_row,
    output logic             o_end_of_frame
);
    import ssr_pkg::*;

    t_cmd_req   f_req, q_req;
    logic       f_push, q_full, q_valid, q_pop;

    // request decode
    ssr_front u_front (
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_digit  (i_digit),
        .i_q_full (q_full),
        .o_req    (f_req),
        .o_push   (f_push),
        .o_stall  (o_stall)
    );

    // command queue
    ssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_req   (f_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (q_pop)
    );

    // raster engine
    ssr_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scale_we     (i_scale_we),
        .i_scale_wdata  (i_scale_wdata),
        .i_q_valid      (q_valid),
        .i_q_req        (q_req),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_glyph        (o_glyph),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

`default_nettype wire

// ===== rtl/ssr_checker.sv =====
// ssr_checker: port-level checks of the renderer, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ssr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [1:0]  i_opcode,
    input wire logic [3:0]  i_digit,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_glyph,
    input wire logic        o_end_of_row,
    input wire logic        o_end_of_frame
);

    // stalled request holds
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, i_valid && o_stall |=> i_valid && $stable(i_opcode) && $stable(i_digit))
    // stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_glyph) && $stable(o_end_of_row) && $stable(o_end_of_frame))
    // frame end is always also a row end
    `ASSERT_CLK(a_eof_eor, i_clk, i_rst_n, o_valid && o_end_of_frame |-> o_end_of_row)
    // cell code is one of the three legal ones
    `ASSERT_CLK(a_glyph_legal, i_clk, i_rst_n, o_valid |-> o_glyph != 2'd3)
    // reset empties the output register
    `ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind scaled_seven_segment_renderer_unit ssr_checker u_ssr_checker (.*);

`default_nettype wire
